// ----- src/fcuh_pkg.sv -----
// Shared types and constants for the four-bit complex unpacker with histograms.
// Used by the channel interfaces, the register block, the histogram bank and the top level.
// No dependencies.
package fcuh_pkg;

   // Operation codes carried in the request word.
   localparam logic [1:0] OP_UNPACK = 2'd0;
   localparam logic [1:0] OP_READ   = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;

   // Register indexes on the configuration port (byte address = 4 * index).
   localparam logic [2:0] REG_POL_COUNT     = 3'd0;
   localparam logic [2:0] REG_SCALE_FIRST   = 3'd1;
   localparam logic [2:0] REG_SCALE_SECOND  = 3'd2;
   localparam logic [2:0] REG_OFFSET_FIRST  = 3'd3;
   localparam logic [2:0] REG_OFFSET_SECOND = 3'd4;

   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;

   // Field widths.
   localparam int OPCODE_BITS = 2;
   localparam int BYTE_BITS   = 8;
   localparam int NIB_BITS    = 4;
   localparam int SELECT_BITS = 6;
   localparam int SCALE_BITS  = 24;
   localparam int VALUE_BITS  = 32;
   localparam int PROD_BITS   = NIB_BITS + SCALE_BITS;

   // Each histogram bank holds one part (real or imaginary) for both polarizations.
   localparam int BANK_DEPTH     = 32;
   localparam int BANK_ADDR_BITS = 5;

   localparam int COUNT_BITS_DEFAULT = 32;

   // Register reset values.
   localparam logic [1:0]            POL_COUNT_RESET = 2'd2;
   localparam logic [SCALE_BITS-1:0] SCALE_RESET     = 24'd65536;
   localparam logic [VALUE_BITS-1:0] OFFSET_RESET    = 32'd0;

   typedef struct packed {
      logic [1:0]            pol_count;
      logic [SCALE_BITS-1:0] scale_first;
      logic [SCALE_BITS-1:0] scale_second;
      logic [VALUE_BITS-1:0] offset_first;
      logic [VALUE_BITS-1:0] offset_second;
   } cfg_type;

   // Commit-stage command to a histogram bank.
   typedef struct packed {
      logic inc;
      logic clr;
   } bank_ctrl_type;

   // One result word as held in the output buffer.
   typedef struct packed {
      logic [VALUE_BITS-1:0] real_value;
      logic [VALUE_BITS-1:0] imag_value;
      logic                  sample_pol;
      logic [VALUE_BITS-1:0] bin_count;
   } rsp_word_type;

endpackage

// ----- src/fcuh_channels.sv -----
// Valid/ready channel interfaces for the request and response words.
// Depends on fcuh_pkg for the field widths.
interface fcuh_req_if import fcuh_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [OPCODE_BITS-1:0] opcode;
   logic [BYTE_BITS-1:0]   packed_byte;
   logic [SELECT_BITS-1:0] bin_select;

   modport source (output valid, output opcode, output packed_byte, output bin_select,
                   input ready);
   modport sink (input valid, input opcode, input packed_byte, input bin_select,
                 output ready);
endinterface

interface fcuh_rsp_if import fcuh_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [VALUE_BITS-1:0] real_value;
   logic [VALUE_BITS-1:0] imag_value;
   logic                  sample_pol;
   logic [VALUE_BITS-1:0] bin_count;

   modport source (output valid, output real_value, output imag_value, output sample_pol,
                   output bin_count, input ready);
   modport sink (input valid, input real_value, input imag_value, input sample_pol,
                 input bin_count, output ready);
endinterface

// ----- src/four_bit_complex_unpack_histogram.sv -----
// Four-bit complex sample unpacker with per-polarization value histograms.
// Request channel req_ch carries opcode, packed_byte and bin_select; response
// channel rsp_ch carries real_value, imag_value, sample_pol and bin_count.
// Every accepted request word produces exactly one response word.
// The csr_ port is APB-style: pol_count, scale_first, scale_second,
// offset_first and offset_second at byte addresses 0, 4, 8, 12 and 16.
// A response word passes through the commit stage registers and then the output
// buffer before it is offered on rsp_ch. Throughput: one word per cycle while
// req_ch.ready is high, set by the single read-modify-write per histogram bank
// per word (real and imaginary parts live in separate banks, each with one read
// and one write port).
// Reset restores the register defaults, the position bit and empties every
// histogram at once through per-entry valid bits; no clearing pass is needed.
// When the receiver stalls, up to two finished words wait in the output
// buffer, and req_ch.ready drops while the buffer and the commit stage
// together hold two words and none of them leaves in that cycle.
// Depends on fcuh_pkg, fcuh_channels, fcuh_csr and fcuh_hist_bank.
module four_bit_complex_unpack_histogram import fcuh_pkg::*; #(
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   fcuh_req_if.sink                 req_ch,
   fcuh_rsp_if.source               rsp_ch,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   cfg_type cfg;

   fcuh_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   // Accept stage: polarization tracking, bank addressing and the products.
   logic                         accept;
   logic                         two_pol;
   logic                         pol;
   logic                         pos_ff, pos_in;
   logic signed [NIB_BITS-1:0]   nib_re, nib_im;
   logic signed [SCALE_BITS-1:0] scale_sel;
   logic signed [PROD_BITS-1:0]  prod_re, prod_im;
   logic [BANK_ADDR_BITS-1:0]    addr_re, addr_im;

   assign accept  = req_ch.valid && req_ch.ready;
   assign two_pol = cfg.pol_count[1];
   assign pol     = two_pol && pos_ff;
   assign nib_re  = req_ch.packed_byte[NIB_BITS-1:0];
   assign nib_im  = req_ch.packed_byte[BYTE_BITS-1:NIB_BITS];

   assign scale_sel = pol ? cfg.scale_second : cfg.scale_first;
   assign prod_re   = nib_re * scale_sel;
   assign prod_im   = nib_im * scale_sel;

   // Bin index is the nibble plus eight, which is the nibble with its top bit flipped.
   always_comb begin
      if (req_ch.opcode == OP_READ) begin
         addr_re = {req_ch.bin_select[5], req_ch.bin_select[3:0]};
         addr_im = {req_ch.bin_select[5], req_ch.bin_select[3:0]};
      end else begin
         addr_re = {pol, ~nib_re[NIB_BITS-1], nib_re[NIB_BITS-2:0]};
         addr_im = {pol, ~nib_im[NIB_BITS-1], nib_im[NIB_BITS-2:0]};
      end
   end

   // Position bit toggles on each sample with two polarizations; clear resets it.
   always_comb begin
      pos_in = pos_ff;
      if (accept) begin
         priority if (req_ch.opcode == OP_UNPACK) begin
            pos_in = two_pol ? ~pos_ff : 1'b0;
         end else if (req_ch.opcode == OP_CLEAR) begin
            pos_in = 1'b0;
         end else begin
            pos_in = pos_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= 1'b0;
      end else begin
         pos_ff <= pos_in;
      end
   end

   // Commit stage registers.
   logic                        s1_valid_ff;
   logic [OPCODE_BITS-1:0]      s1_op_ff;
   logic                        s1_pol_ff;
   logic                        s1_part_ff;
   logic signed [PROD_BITS-1:0] s1_prod_re_ff, s1_prod_im_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff      <= req_ch.opcode;
         s1_pol_ff     <= pol;
         s1_part_ff    <= req_ch.bin_select[4];
         s1_prod_re_ff <= prod_re;
         s1_prod_im_ff <= prod_im;
      end
   end

   // Histogram banks: real parts and imaginary parts.
   bank_ctrl_type         bank_ctrl;
   logic [COUNT_BITS-1:0] count_re, count_im;

   assign bank_ctrl.inc = s1_valid_ff && (s1_op_ff == OP_UNPACK);
   assign bank_ctrl.clr = s1_valid_ff && (s1_op_ff == OP_CLEAR);

   fcuh_hist_bank #(.COUNT_BITS(COUNT_BITS)) u_bank_re (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (addr_re),
      .ctrl    (bank_ctrl),
      .count   (count_re)
   );

   fcuh_hist_bank #(.COUNT_BITS(COUNT_BITS)) u_bank_im (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (addr_im),
      .ctrl    (bank_ctrl),
      .count   (count_im)
   );

   // Offset add with saturation to the signed 32-bit range.
   logic signed [VALUE_BITS-1:0] offset_sel;
   logic signed [VALUE_BITS:0]   sum_re, sum_im;
   logic [VALUE_BITS-1:0]        sat_re, sat_im;
   localparam logic [VALUE_BITS-1:0] SAT_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
   localparam logic [VALUE_BITS-1:0] SAT_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

   assign offset_sel = s1_pol_ff ? cfg.offset_second : cfg.offset_first;
   assign sum_re = {{(VALUE_BITS+1-PROD_BITS){s1_prod_re_ff[PROD_BITS-1]}}, s1_prod_re_ff}
                 + {offset_sel[VALUE_BITS-1], offset_sel};
   assign sum_im = {{(VALUE_BITS+1-PROD_BITS){s1_prod_im_ff[PROD_BITS-1]}}, s1_prod_im_ff}
                 + {offset_sel[VALUE_BITS-1], offset_sel};

   always_comb begin
      if (sum_re[VALUE_BITS] != sum_re[VALUE_BITS-1]) begin
         sat_re = sum_re[VALUE_BITS] ? SAT_MIN : SAT_MAX;
      end else begin
         sat_re = sum_re[VALUE_BITS-1:0];
      end
      if (sum_im[VALUE_BITS] != sum_im[VALUE_BITS-1]) begin
         sat_im = sum_im[VALUE_BITS] ? SAT_MIN : SAT_MAX;
      end else begin
         sat_im = sum_im[VALUE_BITS-1:0];
      end
   end

   // Selected bin count, saturated to 32 bits when the counters are wider.
   logic [COUNT_BITS-1:0] count_sel;
   logic [63:0]           count_wide;
   logic [VALUE_BITS-1:0] count_out;

   assign count_sel  = s1_part_ff ? count_im : count_re;
   assign count_wide = 64'(count_sel);
   assign count_out  = (count_wide > 64'h0000_0000_FFFF_FFFF) ? '1 : count_wide[31:0];

   // Response word assembly.
   rsp_word_type s1_word;

   always_comb begin
      s1_word = '0;
      unique case (s1_op_ff)
         OP_UNPACK: begin
            s1_word.real_value = sat_re;
            s1_word.imag_value = sat_im;
            s1_word.sample_pol = s1_pol_ff;
         end
         OP_READ: begin
            s1_word.bin_count = count_out;
         end
         default: begin
            s1_word = '0;
         end
      endcase
   end

   // Two-entry output buffer decouples the commit stage from receiver stalls.
   rsp_word_type buf_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   fill_ff, fill_in;
   logic         push, pop;
   logic [1:0]   in_flight;

   assign push      = s1_valid_ff;
   assign pop       = rsp_ch.valid && rsp_ch.ready;
   assign in_flight = fill_ff + 2'(s1_valid_ff);

   // Room for a new word once everything in flight has a buffer slot.
   assign req_ch.ready = (in_flight < 2'd2) || ((in_flight == 2'd2) && pop);

   assign wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
   assign rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
   assign fill_in   = fill_ff + 2'(push) - 2'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         buf_ff[wr_ptr_ff] <= s1_word;
      end
   end

   assign rsp_ch.valid      = (fill_ff != 2'd0);
   assign rsp_ch.real_value = buf_ff[rd_ptr_ff].real_value;
   assign rsp_ch.imag_value = buf_ff[rd_ptr_ff].imag_value;
   assign rsp_ch.sample_pol = buf_ff[rd_ptr_ff].sample_pol;
   assign rsp_ch.bin_count  = buf_ff[rd_ptr_ff].bin_count;

endmodule

// ----- src/fcuh_csr.sv -----
// APB-style configuration registers: polarization count, scales and offsets.
// Depends on fcuh_pkg for register indexes, reset values and cfg_type.
module fcuh_csr import fcuh_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready,
   output cfg_type                  cfg
);

   cfg_type    cfg_ff, cfg_in;
   logic [2:0] reg_index;
   logic       wr_en;

   assign pready    = 1'b1;
   assign reg_index = paddr[CSR_ADDR_BITS-1:2];
   assign wr_en     = psel && penable && pwrite;
   assign cfg       = cfg_ff;

   // Register writes; addresses beyond the list are ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_index)
            REG_POL_COUNT:     cfg_in.pol_count     = pwdata[1:0];
            REG_SCALE_FIRST:   cfg_in.scale_first   = pwdata[SCALE_BITS-1:0];
            REG_SCALE_SECOND:  cfg_in.scale_second  = pwdata[SCALE_BITS-1:0];
            REG_OFFSET_FIRST:  cfg_in.offset_first  = pwdata;
            REG_OFFSET_SECOND: cfg_in.offset_second = pwdata;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pol_count     <= POL_COUNT_RESET;
         cfg_ff.scale_first   <= SCALE_RESET;
         cfg_ff.scale_second  <= SCALE_RESET;
         cfg_ff.offset_first  <= OFFSET_RESET;
         cfg_ff.offset_second <= OFFSET_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read-back of the stored register bits.
   always_comb begin
      unique case (reg_index)
         REG_POL_COUNT:     prdata = {30'd0, cfg_ff.pol_count};
         REG_SCALE_FIRST:   prdata = {8'd0, cfg_ff.scale_first};
         REG_SCALE_SECOND:  prdata = {8'd0, cfg_ff.scale_second};
         REG_OFFSET_FIRST:  prdata = cfg_ff.offset_first;
         REG_OFFSET_SECOND: prdata = cfg_ff.offset_second;
         default:           prdata = '0;
      endcase
   end

endmodule

// ----- src/fcuh_hist_bank.sv -----
// One histogram bank: a synchronous memory of saturating bin counters with
// read-modify-write, write forwarding and per-entry valid bits for instant clearing.
// Depends on fcuh_pkg for bank geometry and bank_ctrl_type.
module fcuh_hist_bank import fcuh_pkg::*; #(
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      rd_en,
   input  logic [BANK_ADDR_BITS-1:0] rd_addr,
   input  bank_ctrl_type             ctrl,
   output logic [COUNT_BITS-1:0]     count
);

   logic [COUNT_BITS-1:0]     mem [BANK_DEPTH];
   logic [COUNT_BITS-1:0]     rd_data_ff;
   logic [BANK_ADDR_BITS-1:0] addr_ff;
   logic [BANK_DEPTH-1:0]     valid_ff, valid_in;
   logic                      fwd_valid_ff, fwd_valid_in;
   logic [BANK_ADDR_BITS-1:0] fwd_addr_ff;
   logic [COUNT_BITS-1:0]     fwd_data_ff;
   logic [COUNT_BITS-1:0]     next_count;

   // Read port: data is registered, the address follows the word into the commit stage.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
         addr_ff    <= rd_addr;
      end
   end

   // Current bin value: the last write wins over stale memory data, a cleared entry reads zero.
   always_comb begin
      priority if (fwd_valid_ff && (fwd_addr_ff == addr_ff)) begin
         count = fwd_data_ff;
      end else if (valid_ff[addr_ff]) begin
         count = rd_data_ff;
      end else begin
         count = '0;
      end
   end

   // Saturating increment.
   assign next_count = (&count) ? count : count + COUNT_BITS'(1);

   // Write port.
   always_ff @(posedge clock) begin
      if (ctrl.inc) begin
         mem[addr_ff] <= next_count;
      end
   end

   // Forwarding register holds the most recent write.
   always_ff @(posedge clock) begin
      if (ctrl.inc) begin
         fwd_addr_ff <= addr_ff;
         fwd_data_ff <= next_count;
      end
   end

   // Valid bits and forwarding flag.
   always_comb begin
      valid_in     = valid_ff;
      fwd_valid_in = fwd_valid_ff;
      if (ctrl.clr) begin
         valid_in     = '0;
         fwd_valid_in = 1'b0;
      end else if (ctrl.inc) begin
         valid_in[addr_ff] = 1'b1;
         fwd_valid_in      = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         fwd_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         fwd_valid_ff <= fwd_valid_in;
      end
   end

endmodule

// ----- sim/four_bit_complex_unpack_histogram_test.sv -----
// Self-checking bench for the four-bit complex unpacker with value histograms.
// Drives request words and register writes, predicts each response word and compares them.
// Depends on fcuh_pkg, fcuh_channels and the four_bit_complex_unpack_histogram top level.
`timescale 1ns / 1ps

module four_bit_complex_unpack_histogram_test;
   import fcuh_pkg::*;

   // Opcode value that the block must ignore.
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam int PHASE_COUNT   = 9;
   localparam int WORDS_PER_PHASE = 100;
   localparam int HOLD_CYCLES   = 150;
   localparam int STALL_LIMIT   = 2000;
   localparam int REPORT_LIMIT  = 10;
   localparam int SETTLE_CYCLES = 8;

   localparam logic signed [63:0] SAT_HIGH = 64'sd2147483647;
   localparam logic signed [63:0] SAT_LOW  = -64'sd2147483648;

   // One row of the directed stimulus; typed rows carry a hand-written expectation.
   typedef struct packed {
      logic [1:0]            op;
      logic [7:0]            pbyte;
      logic [5:0]            sel;
      logic                  typed;
      logic [VALUE_BITS-1:0] real_exp;
      logic [VALUE_BITS-1:0] imag_exp;
      logic                  pol_exp;
      logic [VALUE_BITS-1:0] count_exp;
   } directed_row_type;

   // One full set of register values, as written on the bus.
   typedef struct packed {
      logic [31:0] pol_count;
      logic [31:0] scale_first;
      logic [31:0] scale_second;
      logic [31:0] offset_first;
      logic [31:0] offset_second;
   } reg_setting_type;

   localparam int DIRECTED_ROWS = 24;
   localparam directed_row_type DIRECTED_PLAN [DIRECTED_ROWS] = '{
      '{OP_READ,   8'h00, 6'd0,  1'b1, 32'h0,         32'h0,         1'b0, 32'h0},
      '{OP_READ,   8'h00, 6'd63, 1'b1, 32'h0,         32'h0,         1'b0, 32'h0},
      '{OP_UNPACK, 8'h00, 6'd0,  1'b1, 32'h0,         32'h0,         1'b0, 32'h0},
      '{OP_UNPACK, 8'h87, 6'd0,  1'b1, 32'h0007_0000, 32'hFFF8_0000, 1'b1, 32'h0},
      '{OP_UNPACK, 8'h78, 6'd0,  1'b1, 32'hFFF8_0000, 32'h0007_0000, 1'b0, 32'h0},
      '{OP_UNPACK, 8'hFF, 6'd0,  1'b1, 32'hFFFF_0000, 32'hFFFF_0000, 1'b1, 32'h0},
      '{OP_READ,   8'h00, 6'd0,  1'b0, 32'h0,         32'h0,         1'b0, 32'h0},
      '{OP_READ,   8'h00, 6'd31, 1'b0, 32'h0,         32'h0,         1'b0, 32'h0},
      '{OP_READ,   8'h00, 6'd47, 1'b0, 32'h0,         32'h0,         1'b0, 32'h0},
      '{OP_READ,   8'h00, 6'd48, 1'b0, 32'h0,         32'h0,         1'b0, 32'h0},
      '{OP_UNUSED, 8'hA5, 6'd42, 1'b1, 32'h0,         32'h0,         1'b0, 32'h0},
      '{OP_UNPACK, 8'h5A, 6'd0,  1'b0, 32'h0,         32'h0,         1'b0, 32'h0},
      '{OP_READ,   8'hFF, 6'd26, 1'b0, 32'h0,         32'h0,         1'b0, 32'h0},
      '{OP_CLEAR,  8'h00, 6'd0,  1'b1, 32'h0,         32'h0,         1'b0, 32'h0},
      '{OP_READ,   8'h00, 6'd8,  1'b1, 32'h0,         32'h0,         1'b0, 32'h0},
      '{OP_READ,   8'h00, 6'd47, 1'b1, 32'h0,         32'h0,         1'b0, 32'h0},
      '{OP_UNPACK, 8'h12, 6'd0,  1'b0, 32'h0,         32'h0,         1'b0, 32'h0},
      '{OP_UNPACK, 8'h34, 6'd0,  1'b0, 32'h0,         32'h0,         1'b0, 32'h0},
      '{OP_UNPACK, 8'h99, 6'd0,  1'b0, 32'h0,         32'h0,         1'b0, 32'h0},
      '{OP_UNPACK, 8'h99, 6'd0,  1'b0, 32'h0,         32'h0,         1'b0, 32'h0},
      '{OP_READ,   8'h00, 6'd1,  1'b0, 32'h0,         32'h0,         1'b0, 32'h0},
      '{OP_READ,   8'h00, 6'd55, 1'b0, 32'h0,         32'h0,         1'b0, 32'h0},
      '{OP_UNUSED, 8'hFF, 6'd63, 1'b1, 32'h0,         32'h0,         1'b0, 32'h0},
      '{OP_READ,   8'h00, 6'd42, 1'b0, 32'h0,         32'h0,         1'b0, 32'h0}
   };

   // Register extremes and corner settings, used before the random settings.
   localparam int FIXED_SETTINGS = 4;
   localparam reg_setting_type CORNER_SETTINGS [FIXED_SETTINGS] = '{
      '{32'd1, 32'h007F_FFFF, 32'hFF80_0000, 32'h7FFF_FFFF, 32'h8000_0000},
      '{32'd0, 32'h0080_0000, 32'h007F_FFFF, 32'h8000_0000, 32'h7FFF_FFFF},
      '{32'd3, 32'h0080_0000, 32'h007F_FFFF, 32'h7FFF_FFFF, 32'h8000_0000},
      '{32'd2, 32'h0000_0000, 32'h0001_0000, 32'h0000_8000, 32'hFFFF_8000}
   };

   logic clock = 1'b0;
   logic reset;

   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   fcuh_req_if req_ch ();
   fcuh_rsp_if rsp_ch ();

   four_bit_complex_unpack_histogram DUT (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // 8 ns clock period.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Shadow copy of the block: registers, position bit and histogram bins.
   cfg_type               shadow_cfg;
   logic                  sample_position;
   logic [VALUE_BITS-1:0] bin_tally [64];

   rsp_word_type pending_words [$];

   int  error_count = 0;
   int  rsp_seen = 0;
   int  unpack_words = 0;
   int  read_words = 0;
   int  clear_words = 0;
   int  ignored_words = 0;
   int  settings_used = 1;
   int  stall_cycles = 0;
   bit  calm_mode = 1'b0;
   bit  hold_pending = 1'b0;

   // Scales one signed nibble, adds the bias and saturates to 32 bits.
   function automatic logic [VALUE_BITS-1:0] scaled_part(logic signed [3:0] part,
                                                         logic signed [23:0] gain,
                                                         logic signed [31:0] bias);
      logic signed [63:0] acc;
      acc = part * gain + bias;
      if (acc > SAT_HIGH) return SAT_HIGH[31:0];
      if (acc < SAT_LOW) return SAT_LOW[31:0];
      return acc[31:0];
   endfunction

   // Counts one nibble value; a full bin stays full.
   function automatic void bump_bin(logic [5:0] idx);
      if (bin_tally[idx] != '1) bin_tally[idx] = bin_tally[idx] + 1'b1;
   endfunction

   // Works out the response word for one accepted request word and advances the shadow state.
   function automatic rsp_word_type predict_word(logic [1:0] op, logic [7:0] pbyte,
                                                 logic [5:0] sel);
      rsp_word_type      w;
      logic              pol;
      logic              dual;
      logic signed [3:0] re_part;
      logic signed [3:0] im_part;
      logic signed [23:0] gain;
      logic signed [31:0] bias;
      w = '0;
      case (op)
         OP_UNPACK: begin
            dual    = shadow_cfg.pol_count >= 2'd2;
            pol     = dual ? sample_position : 1'b0;
            re_part = pbyte[3:0];
            im_part = pbyte[7:4];
            gain    = pol ? shadow_cfg.scale_second : shadow_cfg.scale_first;
            bias    = pol ? shadow_cfg.offset_second : shadow_cfg.offset_first;
            w.real_value = scaled_part(re_part, gain, bias);
            w.imag_value = scaled_part(im_part, gain, bias);
            w.sample_pol = pol;
            // Bin index is the nibble plus eight, which is the nibble with its sign bit flipped.
            bump_bin({pol, 1'b0, pbyte[3:0] ^ 4'h8});
            bump_bin({pol, 1'b1, pbyte[7:4] ^ 4'h8});
            sample_position = dual ? ~sample_position : 1'b0;
         end
         OP_READ: begin
            w.bin_count = bin_tally[sel];
         end
         OP_CLEAR: begin
            foreach (bin_tally[i]) bin_tally[i] = '0;
            sample_position = 1'b0;
         end
         default: begin
         end
      endcase
      return w;
   endfunction

   function automatic void note_failure(string msg);
      error_count++;
      if (error_count <= REPORT_LIMIT) $display("[%0t] mismatch: %s", $realtime, msg);
   endfunction

   // Offers one request word and records its expected response once it is accepted.
   task automatic send_word(logic [1:0] op, logic [7:0] pbyte, logic [5:0] sel,
                            logic typed, rsp_word_type hand_word);
      rsp_word_type w;
      req_ch.opcode      <= op;
      req_ch.packed_byte <= pbyte;
      req_ch.bin_select  <= sel;
      req_ch.valid       <= 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      w = predict_word(op, pbyte, sel);
      pending_words.push_back(typed ? hand_word : w);
      case (op)
         OP_UNPACK: unpack_words++;
         OP_READ:   read_words++;
         OP_CLEAR:  clear_words++;
         default:   ignored_words++;
      endcase
   endtask

   // Random idle cycles on the request side.
   task automatic request_gap();
      while (!calm_mode && $urandom_range(99) < 13) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // Stops offering words and waits until every expected response word has arrived.
   task automatic drain();
      req_ch.valid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // One register write: setup cycle, then access cycle until pready.
   task automatic csr_write(logic [2:0] idx, logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_BITS'({idx, 2'b00});
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         REG_POL_COUNT:     shadow_cfg.pol_count     = value[1:0];
         REG_SCALE_FIRST:   shadow_cfg.scale_first   = value[SCALE_BITS-1:0];
         REG_SCALE_SECOND:  shadow_cfg.scale_second  = value[SCALE_BITS-1:0];
         REG_OFFSET_FIRST:  shadow_cfg.offset_first  = value;
         REG_OFFSET_SECOND: shadow_cfg.offset_second = value;
         default: begin
         end
      endcase
   endtask

   task automatic apply_setting(reg_setting_type s);
      csr_write(REG_POL_COUNT, s.pol_count);
      csr_write(REG_SCALE_FIRST, s.scale_first);
      csr_write(REG_SCALE_SECOND, s.scale_second);
      csr_write(REG_OFFSET_FIRST, s.offset_first);
      csr_write(REG_OFFSET_SECOND, s.offset_second);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      settings_used++;
   endtask

   // Random setting: half the gains and biases are small so results do not always saturate.
   function automatic reg_setting_type random_setting();
      reg_setting_type s;
      s.pol_count     = $urandom;
      s.scale_first   = $urandom_range(1) ? $urandom : 32'($urandom_range(0, 8 << 16)) - (4 << 16);
      s.scale_second  = $urandom_range(1) ? $urandom : 32'($urandom_range(0, 8 << 16)) - (4 << 16);
      s.offset_first  = $urandom_range(1) ? $urandom : 32'($urandom_range(0, 1 << 21)) - (1 << 20);
      s.offset_second = $urandom_range(1) ? $urandom : 32'($urandom_range(0, 1 << 21)) - (1 << 20);
      return s;
   endfunction

   // Receiver: random back-pressure, a calm stretch, and one long hold-off on request.
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= calm_mode || ($urandom_range(99) >= 13);
         end
      end
   end

   // Compares every accepted response word with the oldest expectation.
   always @(posedge clock) begin : response_check
      rsp_word_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         rsp_seen++;
         if (pending_words.size() == 0) begin
            note_failure($sformatf("response word %0d arrived with nothing expected", rsp_seen));
         end else begin
            want = pending_words.pop_front();
            if (rsp_ch.real_value !== want.real_value)
               note_failure($sformatf("word %0d real_value expected %h got %h",
                                      rsp_seen, want.real_value, rsp_ch.real_value));
            if (rsp_ch.imag_value !== want.imag_value)
               note_failure($sformatf("word %0d imag_value expected %h got %h",
                                      rsp_seen, want.imag_value, rsp_ch.imag_value));
            if (rsp_ch.sample_pol !== want.sample_pol)
               note_failure($sformatf("word %0d sample_pol expected %b got %b",
                                      rsp_seen, want.sample_pol, rsp_ch.sample_pol));
            if (rsp_ch.bin_count !== want.bin_count)
               note_failure($sformatf("word %0d bin_count expected %h got %h",
                                      rsp_seen, want.bin_count, rsp_ch.bin_count));
         end
      end
   end

   // Watchdog: ends the run after too many cycles without any transfer.
   always @(posedge clock) begin
      if (reset || csr_psel || (req_ch.valid && req_ch.ready)
          || (rsp_ch.valid && rsp_ch.ready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("Run stopped: no transfer for %0d cycles.", STALL_LIMIT);
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // Main sequence: reset, directed words, then random words under several settings.
   initial begin
      rsp_word_type     hand_word;
      directed_row_type row;
      logic [1:0]       op;
      int               pick;

      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.opcode      <= OP_UNPACK;
      req_ch.packed_byte <= '0;
      req_ch.bin_select  <= '0;
      csr_psel           <= 1'b0;
      csr_penable        <= 1'b0;
      csr_pwrite         <= 1'b0;
      csr_paddr          <= '0;
      csr_pwdata         <= '0;

      shadow_cfg.pol_count     = POL_COUNT_RESET;
      shadow_cfg.scale_first   = SCALE_RESET;
      shadow_cfg.scale_second  = SCALE_RESET;
      shadow_cfg.offset_first  = OFFSET_RESET;
      shadow_cfg.offset_second = OFFSET_RESET;
      sample_position          = 1'b0;
      foreach (bin_tally[i]) bin_tally[i] = '0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed words under the reset register values.
      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         row = DIRECTED_PLAN[r];
         hand_word.real_value = row.real_exp;
         hand_word.imag_value = row.imag_exp;
         hand_word.sample_pol = row.pol_exp;
         hand_word.bin_count  = row.count_exp;
         send_word(row.op, row.pbyte, row.sel, row.typed, hand_word);
         request_gap();
      end

      // Random words, one register setting per phase.
      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         drain();
         apply_setting(ph < FIXED_SETTINGS ? CORNER_SETTINGS[ph] : random_setting());
         calm_mode = (ph == 3);
         for (int i = 0; i < WORDS_PER_PHASE; i++) begin
            if (ph == 5 && i == 10) hold_pending = 1'b1;
            if (ph == 6 && i == 50) drain();
            pick = $urandom_range(99);
            if (pick < 70)      op = OP_UNPACK;
            else if (pick < 88) op = OP_READ;
            else if (pick < 92) op = OP_CLEAR;
            else                op = OP_UNUSED;
            send_word(op, 8'($urandom), 6'($urandom), 1'b0, '0);
            request_gap();
         end
         calm_mode = 1'b0;
      end

      req_ch.valid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Run covered %0d unpack, %0d read, %0d clear and %0d ignored words",
               unpack_words, read_words, clear_words, ignored_words);
      $display("under %0d register settings, with %0d response words checked.",
               settings_used, rsp_seen);
      if (error_count == 0 && pending_words.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches counted.", error_count);
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ----- files.f -----
src/fcuh_pkg.sv
src/fcuh_channels.sv
src/fcuh_csr.sv
src/fcuh_hist_bank.sv
src/four_bit_complex_unpack_histogram.sv
sim/four_bit_complex_unpack_histogram_test.sv
